FILE: rtl/rpsf_pkg.sv
// ----------------------------------------------------------------------------
// rpsf_pkg
// Shared types and constants for the pendulum state-feedback controller.
// ----------------------------------------------------------------------------
package rpsf_pkg;

   // encoder resolution; the angle mapping relies on a power of two
   localparam int COUNTS_PER_REV = 2048;

   localparam logic signed [31:0] TWO_PI_Q = 32'sd411775;
   localparam logic signed [31:0] PI_Q     = 32'sd205887;
   localparam logic signed [31:0] ZONE_Q   = 32'sd34315;
   localparam logic signed [63:0] I32_MAX  = 64'sd2147483647;
   localparam logic signed [63:0] I32_MIN  = -64'sd2147483648;

   localparam int unsigned REG_NUM = 8;
   localparam int unsigned ADDR_W  = 5;

   localparam logic [2:0] REG_GAA = 3'd0;
   localparam logic [2:0] REG_GAR = 3'd1;
   localparam logic [2:0] REG_GPA = 3'd2;
   localparam logic [2:0] REG_GPR = 3'd3;
   localparam logic [2:0] REG_AMP = 3'd4;
   localparam logic [2:0] REG_HPR = 3'd5;
   localparam logic [2:0] REG_CO  = 3'd6;
   localparam logic [2:0] REG_LIM = 3'd7;

   typedef struct packed {
      logic signed [15:0] gain_arm_angle;
      logic signed [15:0] gain_arm_rate;
      logic signed [15:0] gain_pend_angle;
      logic signed [15:0] gain_pend_rate;
      logic [19:0]        ref_amplitude;
      logic [15:0]        ref_half_period;
      logic [15:0]        smooth_coeff;
      logic [21:0]        drive_limit;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        motor_word;
      logic signed [20:0] drive_volts;
      logic [9:0]         led_red;
      logic [9:0]         led_green;
      logic [9:0]         led_blue;
      logic               in_zone;
      logic               ref_positive;
   } rsp_type;

   // rounding divide by 2^sh, ties away from zero
   function automatic logic signed [63:0] rshift_round(input logic signed [63:0] v,
                                                     input int sh);
      logic [63:0] mag;
      mag = v[63] ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      return v[63] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
      if (v > I32_MAX) return I32_MAX;
      if (v < I32_MIN) return I32_MIN;
      return v;
   endfunction

endpackage

FILE: rtl/rotary_pendulum_state_feedback_top.sv
// The shared 33x33 multiplier runs thirteen products per sample, each issued
// and then captured from its registered product.
// req_tready is low while a sample is in flight or a response is held.
// Reset (synchronous, active high) restores register defaults and state.
// ----------------------------------------------------------------------------
// rotary_pendulum_state_feedback_top
// Pendulum state-feedback controller with APB-style configuration.
// ----------------------------------------------------------------------------
module rotary_pendulum_state_feedback_top #(
   parameter int SAMPLE_RATE_HZ = 1000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // arm_count[23:0], pend_count[47:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // motor_word, drive_volts, led_red, led_green,
                                    // led_blue, in_zone, ref_positive, zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rpsf_pkg::*;
   cfg_type cfg;
   rsp_type rsp, out_ff;
   logic busy, done, valid_ff;

   rpsf_csr u_csr (.clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
                   .csr_pwdata, .csr_prdata, .cfg);

   rpsf_seq #(.SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)) u_seq (
      .clock, .reset, .cfg, .start(req_tvalid & req_tready),
      .arm_count(req_tdata[23:0]), .pend_count(req_tdata[47:24]),
      .busy, .done, .rsp);

   assign csr_pready = 1'b1;
   assign req_tready = ~busy & ~valid_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {3'd0, out_ff.ref_positive, out_ff.in_zone, out_ff.led_blue,
                       out_ff.led_green, out_ff.led_red, out_ff.drive_volts,
                       out_ff.motor_word};

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (done) valid_ff <= 1'b1;
      else if (rsp_tready) valid_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (done) out_ff <= rsp;
   end
endmodule

FILE: rtl/rpsf_mul.sv
// ----------------------------------------------------------------------------
// rpsf_mul
// Shared signed multiplier, 33 x 33 bits, registered product.
// ----------------------------------------------------------------------------
module rpsf_mul (
   input  logic                clock,
   input  logic signed [32:0]  op_a,
   input  logic signed [32:0]  op_b,
   output logic signed [63:0]  prod_ff
);
   logic signed [65:0] prod_in;
   assign prod_in = op_a * op_b;
   always_ff @(posedge clock) begin
      prod_ff <= prod_in[63:0];
   end
endmodule

FILE: rtl/rpsf_csr.sv
// ----------------------------------------------------------------------------
// rpsf_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module rpsf_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [rpsf_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output rpsf_pkg::cfg_type      cfg
);
   import rpsf_pkg::*;
   cfg_type cfg_ff;
   logic    wr_en;
   logic [2:0] idx;

   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign idx   = csr_paddr[4:2];
   assign cfg   = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_arm_angle  <= -16'sd436;
         cfg_ff.gain_arm_rate   <= -16'sd200;
         cfg_ff.gain_pend_angle <= 16'sd5015;
         cfg_ff.gain_pend_rate  <= 16'sd372;
         cfg_ff.ref_amplitude   <= 20'd32768;
         cfg_ff.ref_half_period <= 16'd1001;
         cfg_ff.smooth_coeff    <= 16'd62337;
         cfg_ff.drive_limit     <= 22'd983040;
      end else if (wr_en && csr_paddr[1:0] == 2'b00) begin
         case (idx)
            REG_GAA: cfg_ff.gain_arm_angle  <= csr_pwdata[15:0];
            REG_GAR: cfg_ff.gain_arm_rate   <= csr_pwdata[15:0];
            REG_GPA: cfg_ff.gain_pend_angle <= csr_pwdata[15:0];
            REG_GPR: cfg_ff.gain_pend_rate  <= csr_pwdata[15:0];
            REG_AMP: cfg_ff.ref_amplitude   <= csr_pwdata[19:0];
            REG_HPR: cfg_ff.ref_half_period <= csr_pwdata[15:0];
            REG_CO:  cfg_ff.smooth_coeff    <= csr_pwdata[15:0];
            REG_LIM: cfg_ff.drive_limit     <= csr_pwdata[21:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         case (idx)
            REG_GAA: csr_prdata = {{16{cfg_ff.gain_arm_angle[15]}}, cfg_ff.gain_arm_angle};
            REG_GAR: csr_prdata = {{16{cfg_ff.gain_arm_rate[15]}}, cfg_ff.gain_arm_rate};
            REG_GPA: csr_prdata = {{16{cfg_ff.gain_pend_angle[15]}}, cfg_ff.gain_pend_angle};
            REG_GPR: csr_prdata = {{16{cfg_ff.gain_pend_rate[15]}}, cfg_ff.gain_pend_rate};
            REG_AMP: csr_prdata = {12'd0, cfg_ff.ref_amplitude};
            REG_HPR: csr_prdata = {16'd0, cfg_ff.ref_half_period};
            REG_CO:  csr_prdata = {16'd0, cfg_ff.smooth_coeff};
            REG_LIM: csr_prdata = {10'd0, cfg_ff.drive_limit};
            default: csr_prdata = '0;
         endcase
      end
   end
endmodule

FILE: rtl/rpsf_seq.sv
// ----------------------------------------------------------------------------
// rpsf_seq
// Sequencer: steps one sample through the shared multiplier.
// ----------------------------------------------------------------------------
module rpsf_seq #(
   parameter int SAMPLE_RATE_HZ = 1000
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rpsf_pkg::cfg_type    cfg,
   input  logic                 start,
   input  logic signed [23:0]   arm_count,
   input  logic signed [23:0]   pend_count,
   output logic                 busy,
   output logic                 done,
   output rpsf_pkg::rsp_type    rsp
);
   import rpsf_pkg::*;

   localparam int CPR_W = $clog2(COUNTS_PER_REV);

   // step codes; each multiply step issues, then captures the registered product
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_TH   = 5'd1;
   localparam logic [4:0] S_AL   = 5'd2;
   localparam logic [4:0] S_RA   = 5'd3;
   localparam logic [4:0] S_RP   = 5'd4;
   localparam logic [4:0] S_FA1  = 5'd5;
   localparam logic [4:0] S_FA2  = 5'd6;
   localparam logic [4:0] S_FP1  = 5'd7;
   localparam logic [4:0] S_FP2  = 5'd8;
   localparam logic [4:0] S_K1   = 5'd9;
   localparam logic [4:0] S_K2   = 5'd10;
   localparam logic [4:0] S_K3   = 5'd11;
   localparam logic [4:0] S_K4   = 5'd12;
   localparam logic [4:0] S_MW   = 5'd13;
   localparam logic [4:0] S_OUT  = 5'd14;

   logic [4:0]  st_ff, st_in;
   logic        wait_ff, wait_in;
   logic signed [63:0] theta_ff, alpha_ff, tmp_ff, acc_ff, u_ff;
   logic signed [31:0] prev_a_ff, prev_p_ff, fa_ff, fp_ff;
   logic        sgn_ff;
   logic [15:0] tick_ff;
   logic signed [23:0] ac_ff, pc_ff;
   logic        zone_ff;
   rsp_type     rsp_ff;

   logic signed [32:0] op_a, op_b;
   logic signed [63:0] prod;
   logic signed [63:0] r_val, lim;

   logic signed [63:0] e_abs, p250;
   logic [63:0] pmag;
   logic [13:0] mw_x;
   logic [31:0] mw_p;
   logic [15:0] mw_q;

   rpsf_mul u_mul (.clock(clock), .op_a(op_a), .op_b(op_b), .prod_ff(prod));

   assign busy = (st_ff != S_IDLE);
   assign done = (st_ff == S_OUT);
   assign rsp  = rsp_ff;
   assign r_val = sgn_ff ? 64'(cfg.ref_amplitude) : -64'(cfg.ref_amplitude);
   assign lim  = (cfg.drive_limit > 22'd1048575) ? 64'sd1048575 : 64'(cfg.drive_limit);

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (st_ff)
         S_TH: begin op_a = -33'(ac_ff); op_b = 33'(TWO_PI_Q); end
         S_AL: begin op_a = 33'({1'b0, pc_ff[CPR_W-1:0]}); op_b = 33'(TWO_PI_Q); end
         S_RA: begin op_a = 33'(sat32(64'(theta_ff - 64'(prev_a_ff))));
            op_b = 33'(SAMPLE_RATE_HZ); end
         S_RP: begin op_a = 33'(sat32(64'(alpha_ff - 64'(prev_p_ff))));
            op_b = 33'(SAMPLE_RATE_HZ); end
         S_FA1: begin op_a = 33'(sat32(tmp_ff));
            op_b = 33'sd65536 - 33'(cfg.smooth_coeff); end
         S_FP1: begin op_a = 33'(sat32(acc_ff));
            op_b = 33'sd65536 - 33'(cfg.smooth_coeff); end
         S_FA2: begin op_a = 33'(fa_ff); op_b = 33'(cfg.smooth_coeff); end
         S_FP2: begin op_a = 33'(fp_ff); op_b = 33'(cfg.smooth_coeff); end
         S_K1: begin op_a = 33'(cfg.gain_arm_angle); op_b = 33'(r_val - theta_ff); end
         S_K2: begin op_a = 33'(cfg.gain_arm_rate); op_b = -33'(fa_ff); end
         S_K3: begin op_a = 33'(cfg.gain_pend_angle); op_b = -33'(alpha_ff); end
         S_K4: begin op_a = 33'(cfg.gain_pend_rate); op_b = -33'(fp_ff); end
         S_MW: begin op_a = -33'(u_ff); op_b = 33'sd625; end
         default: ;
      endcase
   end

   always_comb begin
      st_in   = st_ff;
      wait_in = 1'b0;
      if (st_ff == S_IDLE) begin
         if (start) st_in = S_TH;
      end else if (st_ff == S_OUT) begin
         st_in = S_IDLE;
      end else if (!wait_ff) begin
         wait_in = 1'b1;
      end else begin
         st_in = st_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         wait_ff   <= 1'b0;
         prev_a_ff <= '0;
         prev_p_ff <= '0;
         fa_ff     <= '0;
         fp_ff     <= '0;
         sgn_ff    <= 1'b1;
         tick_ff   <= '0;
      end else begin
         st_ff   <= st_in;
         wait_ff <= wait_in;
         if (st_ff == S_IDLE && start) begin
            ac_ff <= arm_count;
            pc_ff <= pend_count;
            if (16'(tick_ff + 16'd1) >= cfg.ref_half_period) begin
               sgn_ff  <= ~sgn_ff;
               tick_ff <= '0;
            end else begin
               tick_ff <= tick_ff + 16'd1;
            end
         end
         // raw arm rate in tmp, raw pend rate in acc, arm filter term in u
         if (wait_ff) begin
            case (st_ff)
               S_TH: theta_ff <= sat32(rshift_round(prod, CPR_W));
               S_AL: begin
                  alpha_ff <= rshift_round(prod, CPR_W) - 64'(PI_Q);
                  zone_ff  <= 1'b0;
               end
               S_RA: tmp_ff <= prod;
               S_RP: acc_ff <= prod;
               S_FA1: u_ff <= prod;
               S_FA2: begin
                  fa_ff     <= 32'(sat32(rshift_round(u_ff + prod, 16)));
                  prev_a_ff <= 32'(theta_ff);
               end
               S_FP1: tmp_ff <= prod;
               S_FP2: begin
                  fp_ff     <= 32'(sat32(rshift_round(tmp_ff + prod, 16)));
                  prev_p_ff <= 32'(alpha_ff);
                  zone_ff   <= (alpha_ff > -64'(ZONE_Q)) && (alpha_ff < 64'(ZONE_Q));
               end
               S_K1: u_ff <= prod;
               S_K2, S_K3: u_ff <= u_ff + prod;
               S_K4: begin
                  if (zone_ff) begin
                     if (rshift_round(u_ff + prod, 8) > lim) u_ff <= lim;
                     else if (rshift_round(u_ff + prod, 8) < -lim) u_ff <= -lim;
                     else u_ff <= rshift_round(u_ff + prod, 8);
                  end else begin
                     u_ff <= '0;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // motor word: -u*625 / (15*2^16), truncated toward zero; the /15 is a reciprocal
   // multiply, exact for quotients of the clamped drive range
   always_comb begin
      e_abs = r_val - theta_ff;
      if (e_abs < 0) e_abs = -e_abs;
      p250 = e_abs * 64'sd250;
      pmag = prod[63] ? 64'(-prod) : 64'(prod);
      mw_x = pmag[29:16];
      mw_p = 32'(mw_x) * 32'd17477;
      mw_q = {2'b00, mw_p[31:18]};
      if (prod[63]) mw_q = -mw_q;
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_MW && wait_ff) begin
         rsp_ff.motor_word   <= mw_q | 16'h8000;
         rsp_ff.drive_volts  <= 21'(u_ff);
         rsp_ff.in_zone      <= zone_ff;
         rsp_ff.ref_positive <= sgn_ff;
         if (zone_ff) begin
            rsp_ff.led_red  <= 10'd100;
            rsp_ff.led_blue <= ((p250 >>> 16) >= 999) ? 10'd999 : 10'(p250 >>> 16);
            rsp_ff.led_green <= (p250 >= 64'sd65536000) ? 10'd0 :
                                10'(64'sd1000 - ((p250 + 64'sd65535) >>> 16));
         end else begin
            rsp_ff.led_red   <= 10'd800;
            rsp_ff.led_green <= 10'd150;
            rsp_ff.led_blue  <= 10'd150;
         end
      end
   end
endmodule

FILE: rtl/rpsf_checker.sv
// ----------------------------------------------------------------------------
// rpsf_checker
// Port-level checks on the controller, bound to the top level.
// ----------------------------------------------------------------------------
module rpsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept while response pending");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("ready after accept");
   a_enable_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15]) else $error("motor enable missing");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata)) else $error("data moved");
endmodule

bind rotary_pendulum_state_feedback_top rpsf_checker u_chk (.*);
